FILE: rtl/lpfd_pkg.sv
// Shared types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

    // Header layout and header checks.
    localparam logic [3:0]  HDR_LAST      = 4'd11;
    localparam logic [3:0]  TYPE_END      = 4'd4;
    localparam logic [3:0]  VERSION_END   = 4'd8;
    localparam logic [3:0]  LENGTH_END    = 4'd10;
    localparam logic [15:0] HDR_BYTES     = 16'd12;
    localparam logic [31:0] VERSION_MAIN  = 32'h0000_00D4;
    localparam logic [31:0] VERSION_ALT   = 32'h00D4_0000;
    localparam logic [31:0] TYPE_COMMAND  = 32'h434D_4E44;

    // Register reset values.
    localparam logic [15:0] MAX_FRAME_LEN_RST  = 16'd4160;
    localparam logic [15:0] CMD_KEEP_LIMIT_RST = 16'd4095;

    // Register indexes on the configuration port.
    localparam logic CFG_MAX_FRAME_LEN  = 1'b0;
    localparam logic CFG_CMD_KEEP_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        EV_CMD_BYTE  = 2'd0,
        EV_BAD_LEN   = 2'd1,
        EV_VER_WARN  = 2'd2,
        EV_OTHER_END = 2'd3
    } lpfd_event_t;

    typedef struct packed {
        lpfd_event_t event_res;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        last;
    } lpfd_result_t;

endpackage

FILE: rtl/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer: header parser with per-byte results for command payloads.
//
//  Channel  Dir  Handshake           Payload
//  s_       in   s_tvalid/s_tready   s_tdata = rx_byte, s_tuser = restart
//  m_       out  m_tvalid/m_tready   m_tdata = data_byte, data_valid; m_tuser = event_res;
//                                    m_tlast = last
//  cfg_     in   cfg_valid/cfg_ready cfg_index = register, cfg_data = value
//
// One byte is taken per clock while s_tready is high; any result is registered as it is
// taken. A two-entry output buffer (output register plus skid register) lets the input
// take one more result-producing byte after the consumer stalls; s_tready drops
// while the skid register is full. Reset is synchronous on aresetn and clears the
// parser and restores the register defaults. cfg_ready is always high.
module length_prefixed_frame_deframer
    import lpfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [8] data_valid, [15:9] zero
    output logic [1:0]  m_tuser,   // [1:0] event_res
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0]  max_frame_len_reg;
    logic [15:0]  cmd_keep_limit_reg;

    logic         in_payload_reg,    in_payload_next;
    logic [3:0]   header_count_reg,  header_count_next;
    logic [31:0]  frame_type_reg,    frame_type_next;
    logic [31:0]  frame_version_reg, frame_version_next;
    logic [15:0]  frame_length_reg,  frame_length_next;
    logic [15:0]  payload_count_reg, payload_count_next;

    logic         out_valid_reg;
    lpfd_result_t out_reg;
    logic         skid_valid_reg;
    lpfd_result_t skid_reg;

    logic         res_valid;
    lpfd_result_t res;
    logic         s_xfer;
    logic         m_xfer;
    logic         is_last;
    logic         keep;

    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.data_valid, out_reg.data_byte};
    assign m_tuser  = out_reg.event_res;
    assign m_tlast  = out_reg.last;

    // Payload byte index plus one plus header size reaching the total length marks the end.
    assign is_last = ({1'b0, payload_count_reg} + {1'b0, HDR_BYTES} + 17'd1)
                     >= {1'b0, frame_length_reg};
    assign keep    = payload_count_reg < cmd_keep_limit_reg;

    always_comb begin
        in_payload_next    = in_payload_reg;
        header_count_next  = header_count_reg;
        frame_type_next    = frame_type_reg;
        frame_version_next = frame_version_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (s_tuser) begin
            in_payload_next    = 1'b0;
            header_count_next  = '0;
            frame_type_next    = '0;
            frame_version_next = '0;
            frame_length_next  = '0;
            payload_count_next = '0;
        end else if (!in_payload_reg) begin
            if (header_count_reg < TYPE_END) begin
                frame_type_next = {frame_type_reg[23:0], s_tdata};
            end else if (header_count_reg < VERSION_END) begin
                frame_version_next = {frame_version_reg[23:0], s_tdata};
            end else if (header_count_reg < LENGTH_END) begin
                frame_length_next = {frame_length_reg[7:0], s_tdata};
            end

            if (header_count_reg != HDR_LAST) begin
                header_count_next = header_count_reg + 4'd1;
            end else if (frame_length_reg <= HDR_BYTES
                         || frame_length_reg > max_frame_len_reg) begin
                in_payload_next    = 1'b0;
                header_count_next  = '0;
                frame_type_next    = '0;
                frame_version_next = '0;
                frame_length_next  = '0;
                payload_count_next = '0;
                res_valid          = 1'b1;
                res.event_res      = EV_BAD_LEN;
            end else begin
                header_count_next  = '0;
                in_payload_next    = 1'b1;
                payload_count_next = '0;
                if (frame_version_reg != VERSION_MAIN && frame_version_reg != VERSION_ALT) begin
                    res_valid     = 1'b1;
                    res.event_res = EV_VER_WARN;
                end
            end
        end else begin
            payload_count_next = payload_count_reg + 16'd1;
            if (is_last) begin
                in_payload_next    = 1'b0;
                payload_count_next = '0;
            end
            if (frame_type_reg == TYPE_COMMAND) begin
                res_valid      = 1'b1;
                res.event_res  = EV_CMD_BYTE;
                res.data_byte  = s_tdata;
                res.data_valid = keep;
                res.last       = is_last;
            end else if (is_last) begin
                res_valid     = 1'b1;
                res.event_res = EV_OTHER_END;
                res.last      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_len_reg  <= MAX_FRAME_LEN_RST;
            cmd_keep_limit_reg <= CMD_KEEP_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_FRAME_LEN:  max_frame_len_reg  <= cfg_data;
                CFG_CMD_KEEP_LIMIT: cmd_keep_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg    <= 1'b0;
            header_count_reg  <= '0;
            frame_type_reg    <= '0;
            frame_version_reg <= '0;
            frame_length_reg  <= '0;
            payload_count_reg <= '0;
        end else if (s_xfer) begin
            in_payload_reg    <= in_payload_next;
            header_count_reg  <= header_count_next;
            frame_type_reg    <= frame_type_next;
            frame_version_reg <= frame_version_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_xfer) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (s_xfer && res_valid) begin
                if (!out_valid_reg || m_xfer) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_xfer) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        header_count_reg <= HDR_LAST)
        else $error("header byte count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (header_count_reg == 4'd0))
        else $error("header count not cleared during payload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser) |=> (!in_payload_reg && header_count_reg == 4'd0))
        else $error("restart did not clear the parser");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == EV_CMD_BYTE || m_tuser == EV_OTHER_END))
        else $error("last marked on a header event");
`endif

endmodule

FILE: tb/tb_length_prefixed_frame_deframer.sv
// Self-checking testbench for the length-prefixed frame deframer.
module tb_length_prefixed_frame_deframer;
    import lpfd_pkg::*;

    // How the expectation of a directed row is obtained.
    typedef enum logic [1:0] {
        EXP_PREDICTED,
        EXP_NOTHING,
        EXP_TYPED
    } row_exp_t;

    typedef struct {
        logic [7:0]   rx_byte;
        logic         restart;
        row_exp_t     how;
        lpfd_result_t res;
    } stim_row_t;

    localparam int RUN_LIMIT = 8_000_000;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] rx_byte
    logic        s_tuser = 1'b0;   // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] data_byte, [8] data_valid, [15:9] zero
    logic [1:0]  m_tuser;          // [1:0] event_res
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_MAX_FRAME_LEN;
    logic [15:0] cfg_data = '0;

    // Travels with each input transfer: how its expectation is formed.
    row_exp_t     item_how = EXP_PREDICTED;
    lpfd_result_t item_res = '0;

    // Parser mirror and register copies.
    logic        p_in_payload;
    logic [3:0]  p_hdr_cnt;
    logic [31:0] p_type;
    logic [31:0] p_ver;
    logic [15:0] p_len;
    logic [15:0] p_cnt;
    logic [15:0] lim_max_frame;
    logic [15:0] lim_keep;

    lpfd_result_t pending_results[$];
    int errors = 0;
    int items_sent = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int event_count[4] = '{0, 0, 0, 0};
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    length_prefixed_frame_deframer dut (.*);

    always #5 aclk = ~aclk;

    function automatic void clear_parser();
        p_in_payload = 1'b0;
        p_hdr_cnt = '0;
        p_type = '0;
        p_ver = '0;
        p_len = '0;
        p_cnt = '0;
    endfunction

    // Advances the parser mirror by one byte; returns 1 when a result follows.
    function automatic bit deframe_step(input logic [7:0] b, input logic rst,
                                        output lpfd_result_t r);
        logic at_end;
        logic kept;
        r.event_res = EV_CMD_BYTE;
        r.data_byte = '0;
        r.data_valid = 1'b0;
        r.last = 1'b0;
        if (rst) begin
            clear_parser();
            return 1'b0;
        end
        if (!p_in_payload) begin
            if (p_hdr_cnt < TYPE_END)
                p_type = {p_type[23:0], b};
            else if (p_hdr_cnt < VERSION_END)
                p_ver = {p_ver[23:0], b};
            else if (p_hdr_cnt < LENGTH_END)
                p_len = {p_len[7:0], b};
            if (p_hdr_cnt != HDR_LAST) begin
                p_hdr_cnt = p_hdr_cnt + 4'd1;
                return 1'b0;
            end
            // The length check wins over the version check.
            if (p_len <= HDR_BYTES || p_len > lim_max_frame) begin
                clear_parser();
                r.event_res = EV_BAD_LEN;
                return 1'b1;
            end
            p_hdr_cnt = '0;
            p_in_payload = 1'b1;
            p_cnt = '0;
            if (p_ver != VERSION_MAIN && p_ver != VERSION_ALT) begin
                r.event_res = EV_VER_WARN;
                return 1'b1;
            end
            return 1'b0;
        end
        at_end = ({1'b0, p_cnt} + 17'd1) >= {1'b0, p_len - HDR_BYTES};
        kept = p_cnt < lim_keep;
        p_cnt = p_cnt + 16'd1;
        if (at_end) begin
            p_in_payload = 1'b0;
            p_cnt = '0;
        end
        if (p_type == TYPE_COMMAND) begin
            r.data_byte = b;
            r.data_valid = kept;
            r.last = at_end;
            return 1'b1;
        end
        if (at_end) begin
            r.event_res = EV_OTHER_END;
            r.last = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Transfers on all three channels are observed here, at the edge that completes them.
    always @(posedge aclk) begin : observe
        lpfd_result_t got;
        lpfd_result_t want;
        lpfd_result_t pred;
        bit           has_res;
        if (!aresetn) begin
            clear_parser();
            lim_max_frame = MAX_FRAME_LEN_RST;
            lim_keep = CMD_KEEP_LIMIT_RST;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.event_res = lpfd_event_t'(m_tuser);
                got.data_byte = m_tdata[7:0];
                got.data_valid = m_tdata[8];
                got.last = m_tlast;
                results_seen++;
                event_count[m_tuser]++;
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: event %0d, byte %0d",
                           m_tuser, m_tdata[7:0]);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("event_res", want.event_res, got.event_res);
                    compare_field("data_byte", want.data_byte, got.data_byte);
                    compare_field("data_valid", want.data_valid, got.data_valid);
                    compare_field("last", want.last, got.last);
                end
            end
            // An input transfer sees the register values from before this edge.
            if (s_tvalid && s_tready) begin
                has_res = deframe_step(s_tdata, s_tuser, pred);
                if (item_how == EXP_TYPED)
                    pending_results.push_back(item_res);
                else if (item_how == EXP_PREDICTED && has_res)
                    pending_results.push_back(pred);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_FRAME_LEN)
                    lim_max_frame = cfg_data;
                else
                    lim_keep = cfg_data;
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic rst,
                             input row_exp_t how, input lpfd_result_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= rst;
        item_how <= how;
        item_res <= res;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_random_byte(input logic [7:0] b, input logic rst);
        send_byte(b, rst, EXP_PREDICTED, '0);
    endtask

    // Waits until every expected result has arrived and the pipeline has settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_limits(input logic [15:0] max_v, input logic [15:0] keep_v);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_FRAME_LEN;
        cfg_data <= max_v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_CMD_KEEP_LIMIT;
        cfg_data <= keep_v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sends one frame; a rejected length sends the header alone. Optionally a
    // restart cuts the frame short at a random byte.
    task automatic send_frame(input logic [31:0] ftype, input logic [31:0] fver,
                              input logic [15:0] flen, input logic [15:0] max_now,
                              input bit may_abort);
        logic [95:0] hdr;
        int          total;
        int          cut;
        hdr = {ftype, fver, flen, 16'($urandom)};
        total = (flen <= HDR_BYTES || flen > max_now) ? 12 : int'(flen);
        cut = (may_abort && $urandom_range(99) < 6) ? int'($urandom_range(total - 1)) : -1;
        frames_sent++;
        for (int i = 0; i < total; i++) begin
            if (i == cut) begin
                send_random_byte(8'($urandom), 1'b1);
                return;
            end
            if (i < 12)
                send_random_byte(hdr[95 - 8 * i -: 8], 1'b0);
            else
                send_random_byte(8'($urandom), 1'b0);
        end
    endtask

    function automatic logic [15:0] pick_length(input logic [15:0] max_now);
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'($urandom_range(12));
        if (r < 14 && max_now != 16'hFFFF)
            return $urandom_range(1) ? max_now + 16'd1
                                     : 16'($urandom_range(int'(max_now) + 1, 65535));
        if (r < 20 && max_now <= 16'd76)
            return max_now;
        return 16'(13 + $urandom_range((max_now - 16'd13) < 16'd11 ? max_now - 16'd13 : 11));
    endfunction

    // One unit of random traffic: mostly well-formed frames, some noise.
    task automatic send_random_unit(input logic [15:0] max_now);
        logic [31:0] ftype;
        logic [31:0] fver;
        int          r;
        r = $urandom_range(99);
        if (r < 10) begin
            repeat ($urandom_range(1, 6))
                send_random_byte(8'($urandom), $urandom_range(3) == 0);
            if ($urandom_range(3) != 0)
                send_random_byte(8'($urandom), 1'b1);
            return;
        end
        r = $urandom_range(99);
        if (r < 60)
            ftype = TYPE_COMMAND;
        else if (r < 75)
            ftype = TYPE_COMMAND ^ (32'h1 << $urandom_range(31));
        else
            ftype = $urandom;
        r = $urandom_range(99);
        if (r < 45)
            fver = VERSION_MAIN;
        else if (r < 80)
            fver = VERSION_ALT;
        else if (r < 90)
            fver = $urandom;
        else
            fver = VERSION_MAIN ^ (32'h1 << $urandom_range(31));
        send_frame(ftype, fver, pick_length(max_now), max_now, 1'b1);
    endtask

    function automatic lpfd_result_t mk_res(input lpfd_event_t ev, input logic [7:0] b,
                                            input logic v, input logic l);
        lpfd_result_t r;
        r.event_res = ev;
        r.data_byte = b;
        r.data_valid = v;
        r.last = l;
        return r;
    endfunction

    function automatic stim_row_t row(input logic [7:0] b, input logic rst,
                                      input row_exp_t how, input lpfd_result_t res);
        stim_row_t s;
        s.rx_byte = b;
        s.restart = rst;
        s.how = how;
        s.res = res;
        return s;
    endfunction

    initial begin : stimulus
        stim_row_t   dir_rows[$];
        lpfd_result_t none;
        logic [15:0] max_now;
        logic [15:0] keep_now;
        int          first;
        none = '0;

        // Restart on an idle parser, then a command frame of two payload bytes,
        // then a header whose length and version are both bad.
        dir_rows.push_back(row(8'hA5, 1'b1, EXP_NOTHING, none));
        for (int i = 3; i >= 0; i--)
            dir_rows.push_back(row(TYPE_COMMAND[8 * i +: 8], 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h00, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h00, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h00, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'hD4, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h00, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h0E, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h00, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'hFF, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h00, 1'b0, EXP_PREDICTED, none));
        dir_rows.push_back(row(8'hFF, 1'b0, EXP_TYPED, mk_res(EV_CMD_BYTE, 8'hFF, 1'b1, 1'b1)));
        repeat (11)
            dir_rows.push_back(row(8'hFF, 1'b0, EXP_NOTHING, none));
        dir_rows.push_back(row(8'h00, 1'b0, EXP_TYPED, mk_res(EV_BAD_LEN, 8'h00, 1'b0, 1'b0)));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        max_now = MAX_FRAME_LEN_RST;
        keep_now = CMD_KEEP_LIMIT_RST;
        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx_byte, dir_rows[i].restart, dir_rows[i].how,
                      dir_rows[i].res);

        // A well-formed command frame at the reset limits.
        send_frame(TYPE_COMMAND, VERSION_ALT, 16'd60, max_now, 1'b0);

        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    max_now = 16'd13;
                    keep_now = 16'd1;
                    send_idle_pct = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    max_now = 16'd40;
                    keep_now = 16'd3;
                    send_idle_pct = 0;
                    recv_stall_pct = 88;
                end
                3: begin
                    max_now = 16'hFFFF;
                    keep_now = 16'hFFFF;
                    send_idle_pct = 17;
                    recv_stall_pct = 17;
                end
                4: begin
                    max_now = 16'($urandom_range(13, 300));
                    keep_now = 16'($urandom_range(1, 16));
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                default: begin
                    max_now = 16'($urandom_range(13, 80));
                    keep_now = 16'($urandom_range(1, 8));
                    send_idle_pct = 17;
                    recv_stall_pct = 17;
                end
            endcase
            if (phase != 0)
                program_limits(max_now, keep_now);
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS)
                send_random_unit(max_now);

            if (phase == 0) begin
                // Output held off while command bytes keep coming, so the input stalls.
                wait_drained();
                hold_left = HOLD_CYCLES;
                repeat (4)
                    send_frame(TYPE_COMMAND, VERSION_MAIN, 16'd30, max_now, 1'b0);
            end
        end

        wait_drained();
        $display("Sent %0d input transfers in %0d frames over 6 register settings.",
                 items_sent, frames_sent);
        $display("Checked %0d results: %0d payload, %0d bad length, %0d version, %0d other end.",
                 results_seen, event_count[EV_CMD_BYTE], event_count[EV_BAD_LEN],
                 event_count[EV_VER_WARN], event_count[EV_OTHER_END]);
        if (errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
